/* hw/rtl/sgde_pkg.sv */
`default_nettype none

package sgde_pkg;

  localparam int SampleBits     = 24;
  localparam int DipFracBitsDef = 16;
  localparam int DipBits        = 32;
  localparam int SumBits        = 32;
  localparam int NullBits       = 24;
  localparam int ThrBits        = 16;
  localparam int ModeBits       = 2;
  localparam int CfgIdxBits     = 2;
  localparam int CfgDataBits    = 24;

  localparam logic [CfgIdxBits-1:0] CfgStencilMode  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgNullSample   = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgFlatThreshold = 2'd2;

  localparam logic [ModeBits-1:0] ModeThreePoint = 2'd0;
  localparam logic [ModeBits-1:0] ModeFivePoint  = 2'd1;

  localparam logic [1:0] AxisInline    = 2'd0;
  localparam logic [1:0] AxisCrossline = 2'd1;
  localparam logic [1:0] AxisTime      = 2'd2;

  localparam logic [1:0] RejNone = 2'd0;
  localparam logic [1:0] RejNull = 2'd1;
  localparam logic [1:0] RejFlat = 2'd2;

  localparam logic [ModeBits-1:0]        ModeRst    = ModeThreePoint;
  localparam logic signed [NullBits-1:0] NullRst    = 24'sh80_0000;
  localparam logic [ThrBits-1:0]         FlatThrRst = 16'd1;

  localparam logic [5:0] DivThree = 6'd2;
  localparam logic [5:0] DivFive  = 6'd12;
  localparam logic [5:0] DivSeven = 6'd60;

  typedef struct packed {
    logic [1:0]                   axis;
    logic signed [SampleBits-1:0] s_minus3;
    logic signed [SampleBits-1:0] s_minus2;
    logic signed [SampleBits-1:0] s_minus1;
    logic signed [SampleBits-1:0] s_plus1;
    logic signed [SampleBits-1:0] s_plus2;
    logic signed [SampleBits-1:0] s_plus3;
  } in_word_t;

  typedef struct packed {
    logic signed [DipBits-1:0] inline_dip;
    logic signed [DipBits-1:0] crossline_dip;
    logic [1:0]                reject_code;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHECK,
    ST_DIV_IL,
    ST_WAIT_IL,
    ST_DIV_XL,
    ST_WAIT_XL,
    ST_EMIT
  } ctl_state_e;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_MAG,
    DV_INIT,
    DV_ITER,
    DV_SAT
  } div_state_e;

  function automatic logic [SumBits-1:0] mag32(input logic signed [SumBits-1:0] v);
    logic [SumBits-1:0] u;
    u = v;
    return v[SumBits-1] ? (~u + SumBits'(1)) : u;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/sgde_div.sv */
`default_nettype none

module sgde_div import sgde_pkg::*; #(
  parameter int DIP_FRAC_BITS = DipFracBitsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic signed [SumBits-1:0] num_i,
  input  wire logic signed [SumBits-1:0] den_i,
  output logic                           done_o,
  output logic signed [DipBits-1:0]      res_o
);

  localparam int QuoBits = 32;
  localparam int CntBits = $clog2(QuoBits);
  localparam int ShAmt   = QuoBits - DIP_FRAC_BITS;
  localparam int CmpBits = SumBits + ShAmt;

  div_state_e state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic done_q, done_d;

  logic signed [SumBits-1:0] num_q, den_q;
  logic [SumBits-1:0] nmag_q, dmag_q;
  logic [SumBits-1:0] rem_q, rem_d;
  logic [QuoBits-1:0] quo_q, quo_d;
  logic neg_q, ovf_q;
  logic signed [DipBits-1:0] res_q, res_d;

  logic [SumBits:0] trial;
  logic fits;
  logic ovf_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DV_IDLE: if (start_i) state_d = DV_MAG;
      DV_MAG:  state_d = DV_INIT;
      DV_INIT: state_d = ovf_d ? DV_SAT : DV_ITER;
      DV_ITER: if (cnt_q == CntBits'(QuoBits - 1)) state_d = DV_SAT;
      DV_SAT:  state_d = DV_IDLE;
      default: state_d = DV_IDLE;
    endcase
  end

  always_comb begin
    ovf_d  = CmpBits'(nmag_q) >= (CmpBits'(dmag_q) << ShAmt);
    trial  = {rem_q, quo_q[QuoBits-1]} - {1'b0, dmag_q};
    fits   = !trial[SumBits];
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    res_d  = res_q;
    unique case (state_q)
      DV_INIT: begin
        rem_d = nmag_q >> ShAmt;
        quo_d = QuoBits'(nmag_q << DIP_FRAC_BITS);
        cnt_d = '0;
      end
      DV_ITER: begin
        rem_d = fits ? trial[SumBits-1:0] : {rem_q[SumBits-2:0], quo_q[QuoBits-1]};
        quo_d = {quo_q[QuoBits-2:0], fits};
        cnt_d = cnt_q + CntBits'(1);
      end
      DV_SAT: begin
        done_d = 1'b1;
        if (neg_q) begin
          if (ovf_q || quo_q > 32'h8000_0000) res_d = 32'sh8000_0000;
          else res_d = DipBits'(~quo_q + 32'd1);
        end else begin
          if (ovf_q || quo_q[QuoBits-1]) res_d = 32'sh7FFF_FFFF;
          else res_d = DipBits'(quo_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DV_IDLE && start_i) begin
      num_q <= num_i;
      den_q <= den_i;
    end
    if (state_q == DV_MAG) begin
      nmag_q <= mag32(num_q);
      dmag_q <= mag32(den_q);
      neg_q  <= (num_q != '0) && (num_q[SumBits-1] == den_q[SumBits-1]);
    end
    if (state_q == DV_INIT) ovf_q <= ovf_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

/* hw/rtl/stencil_gradient_dip_estimator_unit.sv */
// Channel | Direction | Handshake               | Word
// in      | input     | in_valid_i / in_ready_o  | in_word_i  (in_word_t)
// out     | output    | out_valid_o / out_ready_i| out_word_o (out_word_t)
// cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// Inline and crossline words pass through IDLE and SUM only. A rejected time word
// goes on through CHECK to EMIT. An accepted time word runs two 32-step restoring
// divisions one after the other on the single shared divider, then EMIT. Reset is
// asynchronous, active low; inline and crossline sums, null flag and registers go
// to defaults. A finished result waits in the output register; a new word is taken
// meanwhile, and only a following time word stalls until that result is taken.
`default_nettype none

module stencil_gradient_dip_estimator_unit import sgde_pkg::*; #(
  parameter int DIP_FRAC_BITS = DipFracBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire in_word_t               in_word_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output out_word_t                   out_word_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i
);

  localparam int AccBits = (SampleBits + 8 > 33) ? SampleBits + 8 : 33;
  localparam logic signed [AccBits-1:0] SumMax = AccBits'(64'sh7FFF_FFFF);
  localparam logic signed [AccBits-1:0] SumMin = AccBits'(-64'sh8000_0000);

  ctl_state_e state_q, state_d;

  logic [ModeBits-1:0]        mode_q;
  logic signed [NullBits-1:0] null_q;
  logic [ThrBits-1:0]         thr_q;

  logic signed [SumBits-1:0] il_sum_q, xl_sum_q, t_sum_q;
  logic null_seen_q;
  logic out_valid_q;

  in_word_t  item_q;
  out_word_t out_word_q;
  logic signed [DipBits-1:0] il_dip_q, xl_dip_q;
  logic [1:0] code_q;

  logic signed [AccBits-1:0] d1, d2, d3, acc;
  logic signed [SumBits-1:0] sum;
  logic nul;
  logic [5:0] stencil_div;
  logic [SumBits+5:0] t_scaled;
  logic [ThrBits+5:0] thr_scaled;
  logic flat;
  logic [1:0] code_d;

  logic in_fire, emit_fire, div_start, div_done;
  logic signed [SumBits-1:0] div_num;
  logic signed [DipBits-1:0] div_res;

  function automatic logic is_null(input logic signed [SampleBits-1:0] s,
                                   input logic signed [NullBits-1:0] n);
    return 32'(s) == 32'(n);
  endfunction

  // stencil sum and null test of the held word
  always_comb begin
    d1 = AccBits'(item_q.s_plus1) - AccBits'(item_q.s_minus1);
    d2 = AccBits'(item_q.s_plus2) - AccBits'(item_q.s_minus2);
    d3 = AccBits'(item_q.s_plus3) - AccBits'(item_q.s_minus3);
    nul = is_null(item_q.s_minus1, null_q) || is_null(item_q.s_plus1, null_q);
    priority case (mode_q)
      ModeThreePoint: begin
        acc = d1;
      end
      ModeFivePoint: begin
        acc = (d1 <<< 3) - d2;
        nul = nul || is_null(item_q.s_minus2, null_q) || is_null(item_q.s_plus2, null_q);
      end
      default: begin
        acc = (d1 <<< 5) + (d1 <<< 3) + (d1 <<< 2) + d1 - ((d2 <<< 3) + d2) + d3;
        nul = nul || is_null(item_q.s_minus2, null_q) || is_null(item_q.s_plus2, null_q)
                  || is_null(item_q.s_minus3, null_q) || is_null(item_q.s_plus3, null_q);
      end
    endcase
    if (acc > SumMax)      sum = SumBits'(SumMax);
    else if (acc < SumMin) sum = SumBits'(SumMin);
    else                   sum = SumBits'(acc);
  end

  // flatness and reject code
  always_comb begin
    priority case (mode_q)
      ModeThreePoint: stencil_div = DivThree;
      ModeFivePoint:  stencil_div = DivFive;
      default:        stencil_div = DivSeven;
    endcase
    t_scaled   = {mag32(t_sum_q), 6'b0};
    thr_scaled = (ThrBits+6)'(thr_q) * (ThrBits+6)'(stencil_div);
    flat       = (t_sum_q == '0) || (t_scaled < (SumBits+6)'(thr_scaled));
    if (null_seen_q) code_d = RejNull;
    else if (flat)   code_d = RejFlat;
    else             code_d = RejNone;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_SUM;
      ST_SUM:     state_d = (item_q.axis == AxisTime) ? ST_CHECK : ST_IDLE;
      ST_CHECK:   state_d = (code_d == RejNone) ? ST_DIV_IL : ST_EMIT;
      ST_DIV_IL:  state_d = ST_WAIT_IL;
      ST_WAIT_IL: if (div_done) state_d = ST_DIV_XL;
      ST_DIV_XL:  state_d = ST_WAIT_XL;
      ST_WAIT_XL: if (div_done) state_d = ST_EMIT;
      ST_EMIT:    if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    in_fire    = in_ready_o && in_valid_i;
    div_start  = (state_q == ST_DIV_IL) || (state_q == ST_DIV_XL);
    div_num    = (state_q == ST_DIV_XL) ? xl_sum_q : il_sum_q;
    emit_fire  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  end

  sgde_div #(
    .DIP_FRAC_BITS(DIP_FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (t_sum_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= ModeRst;
      null_q      <= NullRst;
      thr_q       <= FlatThrRst;
      il_sum_q    <= '0;
      xl_sum_q    <= '0;
      null_seen_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgStencilMode:   mode_q <= cfg_data_i[ModeBits-1:0];
          CfgNullSample:    null_q <= cfg_data_i[NullBits-1:0];
          CfgFlatThreshold: thr_q  <= cfg_data_i[ThrBits-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_SUM) begin
        unique case (item_q.axis)
          AxisInline: begin
            il_sum_q    <= sum;
            null_seen_q <= nul;
          end
          AxisCrossline: begin
            xl_sum_q    <= sum;
            null_seen_q <= null_seen_q || nul;
          end
          AxisTime: null_seen_q <= null_seen_q || nul;
          default: ;
        endcase
      end
      if (emit_fire) begin
        il_sum_q    <= '0;
        xl_sum_q    <= '0;
        null_seen_q <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) item_q <= in_word_i;
    if (state_q == ST_SUM && item_q.axis == AxisTime) t_sum_q <= sum;
    if (state_q == ST_CHECK) begin
      code_q   <= code_d;
      il_dip_q <= '0;
      xl_dip_q <= '0;
    end
    if (state_q == ST_WAIT_IL && div_done) il_dip_q <= div_res;
    if (state_q == ST_WAIT_XL && div_done) xl_dip_q <= div_res;
    if (emit_fire) begin
      out_word_q.inline_dip    <= il_dip_q;
      out_word_q.crossline_dip <= xl_dip_q;
      out_word_q.reject_code   <= code_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result appeared outside emit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.reject_code != RejNone) |->
      (out_word_o.inline_dip == '0) && (out_word_o.crossline_dip == '0))
    else $error("rejected result carries nonzero dip");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WAIT_IL) || (state_q == ST_WAIT_XL))
    else $error("divider finished while not awaited");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (il_sum_q == '0) && (xl_sum_q == '0) && !null_seen_q
                  && (state_q == ST_IDLE))
    else $error("voxel state not cleared after emit");

endmodule

`default_nettype wire

/* test/stencil_gradient_dip_estimator_unit_test.sv */
`default_nettype none

module stencil_gradient_dip_estimator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sgde_pkg::*;

  localparam logic [1:0]                   AxisUnused     = 2'd3;
  localparam logic [ModeBits-1:0]          ModeSevenPoint = 2'd2;
  localparam logic [ModeBits-1:0]          ModeSpare      = 2'd3;
  localparam logic signed [SampleBits-1:0] SampleMax      = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic signed [SampleBits-1:0] SampleMin      = {1'b1, {(SampleBits-1){1'b0}}};
  localparam longint                       SumHi          = 64'sd2147483647;
  localparam longint                       SumLo          = -64'sd2147483648;
  localparam int                           IdlePct        = 6;
  localparam int                           HoldCycles     = 300;
  localparam int                           PhaseWords     = 85;

  logic                   clk      = 1'b0;
  logic                   rst_n    = 1'b0;
  logic                   in_valid = 1'b0;
  in_word_t               in_word  = '0;
  logic                   in_ready;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_word_t              out_word;
  logic                   cfg_we   = 1'b0;
  logic [CfgIdxBits-1:0]  cfg_idx  = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;

  // mirror of the block's registers and voxel state
  logic [ModeBits-1:0]        mode_cfg   = ModeRst;
  logic signed [NullBits-1:0] null_cfg   = NullRst;
  logic [ThrBits-1:0]         thr_cfg    = FlatThrRst;
  longint                     inline_acc = 0;
  longint                     cross_acc  = 0;
  bit                         null_hit   = 1'b0;

  in_word_t  words_queued[$];
  out_word_t dips_due[$];
  int        words_owed = 0;
  int        mismatches = 0;
  bit        in_fire    = 1'b0;
  bit        no_idle    = 1'b0;
  bit        hold_arm   = 1'b0;
  int        hold_left  = 0;

  stencil_gradient_dip_estimator_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint stencil_div(logic [ModeBits-1:0] mode);
    if (mode == ModeThreePoint) return DivThree;
    if (mode == ModeFivePoint) return DivFive;
    return DivSeven;
  endfunction

  function automatic longint stencil_total(in_word_t w, output bit hit);
    longint m3, m2, m1, p1, p2, p3, nv, s;
    m3 = $signed(w.s_minus3);
    m2 = $signed(w.s_minus2);
    m1 = $signed(w.s_minus1);
    p1 = $signed(w.s_plus1);
    p2 = $signed(w.s_plus2);
    p3 = $signed(w.s_plus3);
    nv = null_cfg;
    hit = (m1 == nv) || (p1 == nv);
    if (mode_cfg == ModeThreePoint) begin
      s = p1 - m1;
    end else if (mode_cfg == ModeFivePoint) begin
      hit = hit || (m2 == nv) || (p2 == nv);
      s = 8 * (p1 - m1) - (p2 - m2);
    end else begin
      hit = hit || (m2 == nv) || (p2 == nv) || (m3 == nv) || (p3 == nv);
      s = 45 * (p1 - m1) - 9 * (p2 - m2) + (p3 - m3);
    end
    if (s > SumHi) s = SumHi;
    else if (s < SumLo) s = SumLo;
    return s;
  endfunction

  // -num/den, Q16.16, truncated toward zero, saturated
  function automatic logic [DipBits-1:0] dip_value(longint num, longint den);
    longint q;
    q = (mag(num) << DipFracBitsDef) / mag(den);
    if (num != 0 && ((num < 0) == (den < 0))) begin
      if (q > 64'sh8000_0000) q = 64'sh8000_0000;
      return DipBits'(-q);
    end
    if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
    return DipBits'(q);
  endfunction

  function automatic void track_word(in_word_t w);
    longint    s;
    bit        hit;
    out_word_t r;
    s = stencil_total(w, hit);
    case (w.axis)
      AxisInline: begin
        inline_acc = s;
        null_hit = hit;
      end
      AxisCrossline: begin
        cross_acc = s;
        null_hit = null_hit | hit;
      end
      AxisTime: begin
        null_hit = null_hit | hit;
        r = '0;
        if (null_hit) begin
          r.reject_code = RejNull;
        end else if (s == 0 || mag(s) * 64 < longint'(thr_cfg) * stencil_div(mode_cfg)) begin
          r.reject_code = RejFlat;
        end else begin
          r.reject_code = RejNone;
          r.inline_dip = dip_value(inline_acc, s);
          r.crossline_dip = dip_value(cross_acc, s);
        end
        dips_due.push_back(r);
        inline_acc = 0;
        cross_acc = 0;
        null_hit = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic in_word_t build_word(logic [1:0] ax,
                                          logic signed [SampleBits-1:0] m3,
                                          logic signed [SampleBits-1:0] m2,
                                          logic signed [SampleBits-1:0] m1,
                                          logic signed [SampleBits-1:0] p1,
                                          logic signed [SampleBits-1:0] p2,
                                          logic signed [SampleBits-1:0] p3);
    in_word_t w;
    w.axis = ax;
    w.s_minus3 = m3;
    w.s_minus2 = m2;
    w.s_minus1 = m1;
    w.s_plus1 = p1;
    w.s_plus2 = p2;
    w.s_plus3 = p3;
    return w;
  endfunction

  function automatic logic [SampleBits-1:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 59);
    if (pick == 0) return null_cfg;
    if (pick == 1) return SampleMax;
    if (pick == 2) return SampleMin;
    if (pick < 20) return SampleBits'($urandom_range(0, 128) - 64);
    return SampleBits'($urandom);
  endfunction

  function automatic in_word_t random_word(logic [1:0] ax);
    return build_word(ax, rand_sample(), rand_sample(), rand_sample(),
                      rand_sample(), rand_sample(), rand_sample());
  endfunction

  function automatic logic [CfgDataBits-1:0] pick_null();
    case ($urandom_range(0, 3))
      0: return SampleMin;
      1: return SampleMax;
      2: return '0;
      default: return CfgDataBits'($urandom);
    endcase
  endfunction

  function automatic logic [CfgDataBits-1:0] pick_thr();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CfgDataBits'(1);
      2: return CfgDataBits'(16'hFFFF);
      3: return CfgDataBits'($urandom_range(0, 300));
      default: return CfgDataBits'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic add_word(in_word_t w);
    words_queued.push_back(w);
    words_owed++;
  endtask

  task automatic settle(int tail);
    while (words_owed != 0 || dips_due.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CfgStencilMode:   mode_cfg = val[ModeBits-1:0];
      CfgNullSample:    null_cfg = val;
      CfgFlatThreshold: thr_cfg = val[ThrBits-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (words_queued.size() != 0 && (no_idle || $urandom_range(0, 99) >= IdlePct)) begin
        in_valid <= 1'b1;
        in_word <= words_queued.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_fire = in_valid && in_ready;
    if (in_fire) begin
      words_owed--;
      track_word(in_word);
    end
  end

  always @(negedge clk) begin
    if (hold_arm && hold_left == 0) begin
      hold_left = HoldCycles;
      hold_arm = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (out_valid && out_ready) begin
      if (dips_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: inline %0d crossline %0d code %0d",
                   out_word.inline_dip, out_word.crossline_dip, out_word.reject_code);
      end else begin
        want = dips_due.pop_front();
        if (out_word.inline_dip !== want.inline_dip ||
            out_word.crossline_dip !== want.crossline_dip ||
            out_word.reject_code !== want.reject_code) begin
          mismatches++;
          if (mismatches <= 10)
            $display("dip mismatch: expected %0d %0d code %0d, got %0d %0d code %0d",
                     want.inline_dip, want.crossline_dip, want.reject_code,
                     out_word.inline_dip, out_word.crossline_dip, out_word.reject_code);
        end
      end
    end
  end

  initial begin
    int queued;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: three-point, sentinel at most negative, threshold 1
    add_word(build_word(AxisInline, SampleMin, SampleMin, -8388607, SampleMax,
                        SampleMin, SampleMin));
    add_word(build_word(AxisCrossline, SampleMin, SampleMin, SampleMax, -8388607,
                        SampleMin, SampleMin));
    add_word(build_word(AxisTime, SampleMin, SampleMin, 0, 1, SampleMin, SampleMin));
    add_word(build_word(AxisInline, 0, 0, SampleMin, 5, 0, 0));
    add_word(build_word(AxisCrossline, 0, 0, 1, 2, 0, 0));
    add_word(build_word(AxisTime, 0, 0, 7, 7, 0, 0));
    add_word(build_word(AxisInline, 0, 0, -100, 0, 0, 0));
    add_word(build_word(AxisUnused, SampleMin, SampleMin, SampleMin, SampleMin,
                        SampleMin, SampleMin));
    add_word(build_word(AxisCrossline, 0, 0, 50, 0, 0, 0));
    add_word(build_word(AxisTime, 0, 0, 0, 3, 0, 0));
    add_word(build_word(AxisInline, 0, 0, 0, 9, 0, 0));
    add_word(build_word(AxisCrossline, 0, 0, 0, -4, 0, 0));
    add_word(build_word(AxisTime, 0, 0, 5, 5, 0, 0));
    add_word(build_word(AxisTime, 0, 0, -2, 2, 0, 0));
    add_word(build_word(AxisInline, 0, 0, 0, 1000, 0, 0));
    add_word(build_word(AxisInline, 0, 0, 0, -3000, 0, 0));
    add_word(build_word(AxisTime, 0, 0, -1, 1, 0, 0));
    settle(20);

    write_reg(CfgStencilMode, CfgDataBits'(ModeFivePoint));
    write_reg(CfgNullSample, SampleMax);
    write_reg(CfgFlatThreshold, '0);
    add_word(build_word(AxisInline, 1, 2, 3, 4, 5, 6));
    add_word(build_word(AxisCrossline, 0, -7, 0, 11, 7, 0));
    add_word(build_word(AxisTime, 9, 9, 9, 9, 9, 9));
    add_word(build_word(AxisInline, SampleMax, 0, -20, 20, 0, SampleMax));
    settle(20);

    // stencil changes between the inline word and the rest of the voxel
    write_reg(CfgStencilMode, CfgDataBits'(ModeSpare));
    write_reg(CfgFlatThreshold, CfgDataBits'(16'hFFFF));
    add_word(build_word(AxisCrossline, 1, -1, 0, 0, 1, 1));
    add_word(build_word(AxisTime, -300, -200, -10000, 10000, 200, 300));
    add_word(build_word(AxisTime, 0, 0, 0, 1, 0, 0));
    add_word(build_word(AxisInline, 0, 0, 0, 0, 0, SampleMax));
    add_word(build_word(AxisCrossline, 0, 0, 3, 4, 0, 0));
    add_word(build_word(AxisTime, 0, 0, -5000, 5000, 0, 0));
    settle(20);

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CfgStencilMode, CfgDataBits'(ph % 4));
      write_reg(CfgNullSample, pick_null());
      write_reg(CfgFlatThreshold, pick_thr());
      no_idle = (ph == 2);
      if (ph == 5) hold_arm = 1'b1;
      queued = 0;
      while (queued < PhaseWords) begin
        if ($urandom_range(0, 99) < 85) begin
          add_word(random_word(AxisInline));
          add_word(random_word(AxisCrossline));
          add_word(random_word(AxisTime));
          queued += 3;
        end else begin
          add_word(random_word(2'($urandom_range(0, 3))));
          queued++;
        end
      end
      settle(20);
    end

    write_reg(CfgStencilMode, CfgDataBits'(ModeSevenPoint));
    for (int v = 0; v < 10; v++) begin
      add_word(random_word(AxisInline));
      add_word(random_word(AxisCrossline));
      add_word(random_word(AxisTime));
    end
    settle(100);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
